// ===== hdl/rc4_pkg.sv =====
package rc4_pkg;

  localparam int unsigned SBOX_SIZE = 256;
  localparam int unsigned SBOX_AW   = 8;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef logic [SBOX_AW-1:0] sbox_addr_t;
  typedef logic [7:0]         byte_t;

  // one access request to the S-box per cycle: one write, one read, clear
  typedef struct packed {
    logic       clear;
    logic       wr_en;
    sbox_addr_t wr_addr;
    byte_t      wr_data;
    sbox_addr_t rd_addr;
  } sbox_req_t;

endpackage

// ===== hdl/rc4_ram.sv =====
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/rc4_sbox.sv =====
module rc4_sbox (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rc4_pkg::sbox_req_t req_i,
  output rc4_pkg::byte_t    rdata_o
);
  import rc4_pkg::*;

  // per-entry written flags; an unwritten entry reads as its own index
  logic [SBOX_SIZE-1:0] vld_q;
  logic                 rd_vld_q;
  sbox_addr_t           rd_addr_q;
  byte_t                ram_rdata;

  rc4_ram #(
    .WIDTH(8),
    .DEPTH(SBOX_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wr_en),
    .waddr_i(req_i.wr_addr),
    .wdata_i(req_i.wr_data),
    .raddr_i(req_i.rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[req_i.rd_addr];
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= req_i.rd_addr;
  end

  assign rdata_o = rd_vld_q ? ram_rdata : rd_addr_q;

endmodule

// ===== hdl/rc4_keystream_cipher.sv =====
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+----------------------------------------
// in      | input     | in_valid_i / in_stall_o | cmd_i, byte_in_i, last_i
// out     | output    | out_valid_o/out_stall_i | byte_out_o, end_of_message_o, not_keyed_o
//
// Steps: a key byte is stored and the block returns to idle. A key byte with last is
//   stored and then starts the key schedule, one swap per S-box entry (S-box read,
//   indexed read, two write-backs through the S-box's one write port). A keyed data
//   byte steps through the dependent S[i], S[j], S[t] reads and the swap writes;
//   an unkeyed data byte passes straight into the pending register.
// Reset: asynchronous, active low. The S-box comes out of reset as the identity
//   through per-entry written flags, so no clearing pass is needed.
// Stalls: a finished result waits in a pending register while the output register
//   is held; the next request is taken once the pending result can move out.
module rc4_keystream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           cmd_i,
  input  rc4_pkg::byte_t byte_in_i,
  input  logic           last_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rc4_pkg::byte_t byte_out_o,
  output logic           end_of_message_o,
  output logic           not_keyed_o
);
  import rc4_pkg::*;

  localparam int unsigned KCW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_D1   = 3'd1;  // S[i] back, read S[j]
  localparam logic [2:0] ST_D2   = 3'd2;  // S[j] back, write S[i], read S[t]
  localparam logic [2:0] ST_D3   = 3'd3;  // write S[j], form result
  localparam logic [2:0] ST_K0   = 3'd4;  // read S[n] and key byte
  localparam logic [2:0] ST_K1   = 3'd5;  // update acc, read S[acc]
  localparam logic [2:0] ST_K2   = 3'd6;  // write S[n]
  localparam logic [2:0] ST_K3   = 3'd7;  // write S[acc], next n

  logic [2:0]     state_q, state_d;
  sbox_addr_t     i_q, i_d, j_q, j_d;
  logic           keyed_q, keyed_d;
  logic [KCW-1:0] key_count_q, key_count_d, len_q, len_d;
  logic [KAW-1:0] kidx_q, kidx_d;
  sbox_addr_t     n_q, n_d;
  byte_t          acc_q, acc_d;
  byte_t          si_q, si_d, sj_q, sj_d;
  sbox_addr_t     t_q, t_d;
  byte_t          b_q, b_d;
  logic           last_q, last_d;
  logic           pend_q, pend_d;
  byte_t          res_q, res_d;
  logic           res_last_q, res_last_d, res_nk_q, res_nk_d;
  logic           out_valid_q;
  byte_t          out_byte_q;
  logic           out_last_q, out_nk_q;

  sbox_req_t      sreq;
  byte_t          s_rdata;
  logic           key_we;
  byte_t          key_rdata;

  logic           accept;
  logic           can_load;
  logic           store_ok;
  logic [KCW-1:0] kc_next;
  byte_t          kb;
  byte_t          ks;
  sbox_addr_t     j_new;
  byte_t          acc_new;

  rc4_sbox u_sbox (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .rdata_o(s_rdata)
  );

  rc4_ram #(
    .WIDTH(8),
    .DEPTH(MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_count_q[KAW-1:0]),
    .wdata_i(byte_in_i),
    .raddr_i(kidx_q),
    .rdata_o(key_rdata)
  );

  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || (pend_q && !can_load);
  assign accept     = in_valid_i && !in_stall_o;

  assign store_ok = key_count_q < KCW'(MAX_KEY_BYTES);
  assign kc_next  = store_ok ? KCW'(key_count_q + 1'b1) : key_count_q;
  assign key_we   = accept && (cmd_i == CMD_KEY) && store_ok;

  assign kb      = (len_q == '0) ? 8'h00 : key_rdata;
  assign acc_new = 8'(acc_q + s_rdata + kb);
  assign j_new   = 8'(j_q + s_rdata);
  // forward the swap: S[i] now holds sj, S[j] holds si
  assign ks      = (t_q == i_q) ? sj_q : ((t_q == j_q) ? si_q : s_rdata);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    keyed_d     = keyed_q;
    key_count_d = key_count_q;
    len_d       = len_q;
    kidx_d      = kidx_q;
    n_d         = n_q;
    acc_d       = acc_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    b_d         = b_q;
    last_d      = last_q;
    pend_d      = pend_q && !can_load;
    res_d       = res_q;
    res_last_d  = res_last_q;
    res_nk_d    = res_nk_q;
    sreq        = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_KEY) begin
            key_count_d = kc_next;
            if (last_i) begin
              sreq.clear = 1'b1;   // back to identity
              len_d      = kc_next;
              acc_d      = '0;
              n_d        = '0;
              kidx_d     = '0;
              state_d    = ST_K0;
            end
          end else if (!keyed_q) begin
            res_d      = byte_in_i;
            res_last_d = last_i;
            res_nk_d   = 1'b1;
            pend_d     = 1'b1;
          end else begin
            b_d          = byte_in_i;
            last_d       = last_i;
            i_d          = 8'(i_q + 1'b1);
            sreq.rd_addr = 8'(i_q + 1'b1);
            state_d      = ST_D1;
          end
        end
      end
      ST_D1: begin
        si_d         = s_rdata;
        j_d          = j_new;
        sreq.rd_addr = j_new;
        state_d      = ST_D2;
      end
      ST_D2: begin
        sj_d         = s_rdata;
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = i_q;
        sreq.wr_data = s_rdata;
        t_d          = 8'(si_q + s_rdata);
        sreq.rd_addr = 8'(si_q + s_rdata);
        state_d      = ST_D3;
      end
      ST_D3: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = j_q;
        sreq.wr_data = si_q;
        res_d        = b_q ^ ks;
        res_last_d   = last_q;
        res_nk_d     = 1'b0;
        pend_d       = 1'b1;
        if (last_q) begin
          i_d = '0;
          j_d = '0;
        end
        state_d = ST_IDLE;
      end
      ST_K0: begin
        sreq.rd_addr = n_q;
        state_d      = ST_K1;
      end
      ST_K1: begin
        si_d         = s_rdata;
        acc_d        = acc_new;
        sreq.rd_addr = acc_new;
        if (KCW'(kidx_q) + 1'b1 >= len_q) begin
          kidx_d = '0;
        end else begin
          kidx_d = KAW'(kidx_q + 1'b1);
        end
        state_d = ST_K2;
      end
      ST_K2: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = n_q;
        sreq.wr_data = s_rdata;
        state_d      = ST_K3;
      end
      ST_K3: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = acc_q;
        sreq.wr_data = si_q;
        n_d          = 8'(n_q + 1'b1);
        if (n_q == 8'hFF) begin
          i_d         = '0;
          j_d         = '0;
          key_count_d = '0;
          keyed_d     = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_K0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      keyed_q     <= 1'b0;
      key_count_q <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      keyed_q     <= keyed_d;
      key_count_q <= key_count_d;
      pend_q      <= pend_d;
      if (pend_q && can_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    kidx_q     <= kidx_d;
    n_q        <= n_d;
    acc_q      <= acc_d;
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    b_q        <= b_d;
    last_q     <= last_d;
    res_q      <= res_d;
    res_last_q <= res_last_d;
    res_nk_q   <= res_nk_d;
    if (pend_q && can_load) begin
      out_byte_q <= res_q;
      out_last_q <= res_last_q;
      out_nk_q   <= res_nk_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_out_o       = out_byte_q;
  assign end_of_message_o = out_last_q;
  assign not_keyed_o      = out_nk_q;

endmodule

// ===== hdl/rc4_checker.sv =====
module rc4_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           cmd_i,
  input logic           last_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rc4_pkg::byte_t byte_out_o,
  input logic           end_of_message_o,
  input logic           not_keyed_o
);
  import rc4_pkg::*;

  // a held result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(byte_out_o) && $stable(end_of_message_o)
      && $stable(not_keyed_o))
    else $error("result payload changed while stalled");

  // the final key byte starts the schedule, which holds off requests
  a_sched_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CMD_KEY) && last_i |=> in_stall_o ##1 in_stall_o)
    else $error("request taken during key schedule");

  // once keyed, the block never falls back to pass-through
  a_keyed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !not_keyed_o |=> !(out_valid_o && not_keyed_o))
    else $error("pass-through result after keyed result");

endmodule

bind rc4_keystream_cipher rc4_checker u_rc4_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .cmd_i           (cmd_i),
  .last_i          (last_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .byte_out_o      (byte_out_o),
  .end_of_message_o(end_of_message_o),
  .not_keyed_o     (not_keyed_o)
);
